@@ rtl/assert_macros.svh @@
// Assertion macros used by the top-level RTL file.
// No dependencies; every macro samples on clk, and SPS_ASSERT also uses the module's arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define SPS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define SPS_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/sps_pkg.sv @@
// Package of the shuffled priority selector: request and result structs,
// request and status codes, controller states. No dependencies.
package sps_pkg;

	localparam int REQ_W       = 3;
	localparam int ITEM_W      = 16;
	localparam int PICK_W      = 5;
	localparam int STATUS_W    = 3;
	localparam int MAX_RESULTS = 32;
	localparam int NUM_W       = $clog2(MAX_RESULTS + 1);

	// Request codes
	typedef enum logic [REQ_W-1:0] {
		REQ_LOAD  = 3'd0,
		REQ_START = 3'd1,
		REQ_SWAP  = 3'd2,
		REQ_ADD   = 3'd3,
		REQ_EMIT  = 3'd4
	} req_code_t;

	// Status codes
	typedef enum logic [STATUS_W-1:0] {
		STS_OK         = 3'd0,
		STS_TABLE_FULL = 3'd1,
		STS_PICK_RANGE = 3'd2,
		STS_NO_SHUFFLE = 3'd3,
		STS_SEL_FULL   = 3'd4,
		STS_BUSY       = 3'd5
	} status_code_t;

	// Controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_SWP_A,
		S_SWP_B,
		S_SWP_C,
		S_EM_SRD,
		S_EM_CMP,
		S_EM_FIN
	} state_t;

	typedef struct packed {
		logic [REQ_W-1:0]  req_type;
		logic [ITEM_W-1:0] item_id;
		logic [PICK_W-1:0] random_pick;
	} request_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ITEM_W-1:0]   out_id;
		logic                found;
		logic                last;
	} result_t;

endpackage

@@ rtl/sps_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module sps_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/shuffled_priority_selector.sv @@
// Top level of the shuffled priority selector: controller, counters and result register.
// Depends on sps_pkg, sps_ram and assert_macros.svh.
`include "assert_macros.svh"

// The block keeps an id table and a selection list, each in a one-port-read RAM.
// A transfer is taken when start is high and busy is low. Load, start, add and
// every rejected request finish straight from idle and their result appears on the
// next cycle; a request with an unused code gives no result. A swap step reads the
// table at the pick and at the position through its single read port, then writes
// the two entries back one after the other. An emit with an empty table or an
// empty selection finishes straight from idle. Any other emit walks the table in
// order: it reads each entry, then compares it with one selection entry at a time
// up to the first match, and it stops after the last entry or MAX_RESULTS matches.
// Each result is valid for one cycle on result_valid and cannot be held off by the
// receiver; the final result of each request that gives results has last set.
module shuffled_priority_selector #(
	parameter int TABLE_DEPTH  = 32,
	parameter int SELECT_DEPTH = 32,
	parameter int ID_WIDTH     = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  sps_pkg::request_t   request,
	output logic                result_valid,
	output sps_pkg::result_t    result
);

	localparam int AW  = $clog2(TABLE_DEPTH);
	localparam int TCW = $clog2(TABLE_DEPTH + 1);
	localparam int SAW = (SELECT_DEPTH > 1) ? $clog2(SELECT_DEPTH) : 1;
	localparam int SCW = $clog2(SELECT_DEPTH + 1);
	localparam int CW  = (AW > sps_pkg::PICK_W) ? AW : sps_pkg::PICK_W;
	localparam int NW  = sps_pkg::NUM_W;

	sps_pkg::state_t state_q, state_d;

	logic [TCW-1:0]      tcount_q, tcount_d;
	logic [SCW-1:0]      scount_q, scount_d;
	logic [AW-1:0]       pos_q, pos_d;
	logic                active_q, active_d;
	logic [AW-1:0]       pick_q, pick_d;
	logic [ID_WIDTH-1:0] tmp_q, tmp_d;
	logic [ID_WIDTH-1:0] cand_q, cand_d;
	logic [TCW-1:0]      ti_q, ti_d;
	logic [SCW-1:0]      si_q, si_d;
	logic [NW-1:0]       n_q, n_d;
	logic                pend_valid_q, pend_valid_d;
	logic [ID_WIDTH-1:0] pend_id_q, pend_id_d;
	logic                res_valid_q, res_set;
	sps_pkg::result_t    res_q, res_d;

	// Memory ports
	logic                t_we, s_we;
	logic [AW-1:0]       t_waddr, t_raddr;
	logic [SAW-1:0]      s_waddr, s_raddr;
	logic [ID_WIDTH-1:0] t_wdata, s_wdata, t_rdata, s_rdata;

	logic                accept;
	logic [ID_WIDTH-1:0] id_in;
	logic [TCW-1:0]      ti_nxt;
	logic [SCW-1:0]      si_nxt;
	logic [NW-1:0]       n_nxt;
	logic                hit;
	logic                walk_done;

	assign accept = start && (state_q == sps_pkg::S_IDLE);
	assign busy   = (state_q != sps_pkg::S_IDLE);
	assign id_in  = ID_WIDTH'(request.item_id);
	assign ti_nxt = ti_q + TCW'(1);
	assign si_nxt = si_q + SCW'(1);
	assign n_nxt  = n_q + NW'(1);
	assign hit    = (s_rdata == cand_q);

	sps_ram #(.WIDTH(ID_WIDTH), .DEPTH(TABLE_DEPTH)) u_table_ram (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (t_wdata),
		.raddr (t_raddr),
		.rdata (t_rdata)
	);

	sps_ram #(.WIDTH(ID_WIDTH), .DEPTH(SELECT_DEPTH)) u_sel_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	// Next state, memory accesses and results
	always_comb begin
		state_d      = state_q;
		tcount_d     = tcount_q;
		scount_d     = scount_q;
		pos_d        = pos_q;
		active_d     = active_q;
		pick_d       = pick_q;
		tmp_d        = tmp_q;
		cand_d       = cand_q;
		ti_d         = ti_q;
		si_d         = si_q;
		n_d          = n_q;
		pend_valid_d = pend_valid_q;
		pend_id_d    = pend_id_q;
		walk_done    = 1'b0;

		t_we    = 1'b0;
		t_waddr = tcount_q[AW-1:0];
		t_wdata = id_in;
		t_raddr = '0;
		s_we    = 1'b0;
		s_waddr = scount_q[SAW-1:0];
		s_wdata = id_in;
		s_raddr = '0;

		res_set        = 1'b0;
		res_d.status   = sps_pkg::STS_OK;
		res_d.out_id   = '0;
		res_d.found    = 1'b0;
		res_d.last     = 1'b1;

		case (state_q)
			sps_pkg::S_IDLE: begin
				if (accept) begin
					case (request.req_type)
						sps_pkg::REQ_LOAD: begin
							res_set = 1'b1;
							if (active_q) begin
								res_d.status = sps_pkg::STS_BUSY;
							end else if (tcount_q >= TCW'(TABLE_DEPTH)) begin
								res_d.status = sps_pkg::STS_TABLE_FULL;
							end else begin
								t_we     = 1'b1;
								tcount_d = tcount_q + TCW'(1);
							end
						end
						sps_pkg::REQ_START: begin
							res_set = 1'b1;
							if (active_q) begin
								res_d.status = sps_pkg::STS_BUSY;
							end else if (tcount_q >= TCW'(2)) begin
								pos_d    = AW'(tcount_q - TCW'(1));
								active_d = 1'b1;
							end
						end
						sps_pkg::REQ_SWAP: begin
							if (!active_q) begin
								res_set      = 1'b1;
								res_d.status = sps_pkg::STS_NO_SHUFFLE;
							end else if (CW'(request.random_pick) > CW'(pos_q)) begin
								res_set      = 1'b1;
								res_d.status = sps_pkg::STS_PICK_RANGE;
							end else begin
								// read the picked entry first
								t_raddr = AW'(request.random_pick);
								pick_d  = AW'(request.random_pick);
								state_d = sps_pkg::S_SWP_A;
							end
						end
						sps_pkg::REQ_ADD: begin
							res_set = 1'b1;
							if (scount_q >= SCW'(SELECT_DEPTH)) begin
								res_d.status = sps_pkg::STS_SEL_FULL;
							end else begin
								s_we     = 1'b1;
								scount_d = scount_q + SCW'(1);
							end
						end
						sps_pkg::REQ_EMIT: begin
							if (active_q) begin
								res_set      = 1'b1;
								res_d.status = sps_pkg::STS_BUSY;
							end else if (tcount_q == '0 || scount_q == '0) begin
								res_set  = 1'b1;
								scount_d = '0;
							end else begin
								t_raddr      = '0;
								ti_d         = '0;
								n_d          = '0;
								pend_valid_d = 1'b0;
								state_d      = sps_pkg::S_EM_SRD;
							end
						end
						default: begin
						end
					endcase
				end
			end

			// Swap: hold table[pick], read table[pos]
			sps_pkg::S_SWP_A: begin
				tmp_d   = t_rdata;
				t_raddr = pos_q;
				state_d = sps_pkg::S_SWP_B;
			end

			// table[pick] <= table[pos]
			sps_pkg::S_SWP_B: begin
				t_we    = 1'b1;
				t_waddr = pick_q;
				t_wdata = t_rdata;
				state_d = sps_pkg::S_SWP_C;
			end

			// table[pos] <= old table[pick], step down
			sps_pkg::S_SWP_C: begin
				t_we     = 1'b1;
				t_waddr  = pos_q;
				t_wdata  = tmp_q;
				pos_d    = pos_q - AW'(1);
				active_d = (pos_q != AW'(1));
				res_set  = 1'b1;
				state_d  = sps_pkg::S_IDLE;
			end

			// Emit: latch table entry, start selection scan
			sps_pkg::S_EM_SRD: begin
				cand_d  = t_rdata;
				s_raddr = '0;
				si_d    = '0;
				state_d = sps_pkg::S_EM_CMP;
			end

			// Emit: compare one selection entry per cycle
			sps_pkg::S_EM_CMP: begin
				if (hit) begin
					// older pending match goes out, this one waits for its last flag
					if (pend_valid_q) begin
						res_set      = 1'b1;
						res_d.out_id = sps_pkg::ITEM_W'(pend_id_q);
						res_d.found  = 1'b1;
						res_d.last   = 1'b0;
					end
					pend_valid_d = 1'b1;
					pend_id_d    = cand_q;
					n_d          = n_nxt;
					walk_done    = (n_nxt == NW'(sps_pkg::MAX_RESULTS)) || (ti_nxt >= tcount_q);
				end else if (si_nxt < scount_q) begin
					si_d    = si_nxt;
					s_raddr = si_nxt[SAW-1:0];
				end else begin
					walk_done = (ti_nxt >= tcount_q);
				end
				if (hit || !(si_nxt < scount_q)) begin
					if (walk_done) begin
						state_d = sps_pkg::S_EM_FIN;
					end else begin
						ti_d    = ti_nxt;
						t_raddr = ti_nxt[AW-1:0];
						state_d = sps_pkg::S_EM_SRD;
					end
				end
			end

			// Emit: final result, selection cleared
			sps_pkg::S_EM_FIN: begin
				res_set  = 1'b1;
				scount_d = '0;
				if (pend_valid_q) begin
					res_d.out_id = sps_pkg::ITEM_W'(pend_id_q);
					res_d.found  = 1'b1;
				end
				state_d = sps_pkg::S_IDLE;
			end

			default: begin
				state_d = sps_pkg::S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sps_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tcount_q     <= '0;
			scount_q     <= '0;
			pos_q        <= '0;
			active_q     <= 1'b0;
			ti_q         <= '0;
			si_q         <= '0;
			n_q          <= '0;
			pend_valid_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			tcount_q     <= tcount_d;
			scount_q     <= scount_d;
			pos_q        <= pos_d;
			active_q     <= active_d;
			ti_q         <= ti_d;
			si_q         <= si_d;
			n_q          <= n_d;
			pend_valid_q <= pend_valid_d;
			res_valid_q  <= res_set;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		pick_q    <= pick_d;
		tmp_q     <= tmp_d;
		cand_q    <= cand_d;
		pend_id_q <= pend_id_d;
		if (res_set) begin
			res_q <= res_d;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	// Checks
	`SPS_ASSERT(a_tcount_range, tcount_q <= TCW'(TABLE_DEPTH), "table count beyond depth")
	`SPS_ASSERT(a_active_pos, active_q |-> (pos_q != '0), "shuffle active at position zero")
	`SPS_ASSERT(a_done_result, $fell(busy) |-> result_valid, "busy ended without a final result")
	`SPS_ASSERT(a_found_ok, (result_valid && result.found) |-> (result.status == sps_pkg::STS_OK), "match reported with error status")

endmodule

@@ bench/tb_shuffled_priority_selector.sv @@
// Self-checking bench for shuffled_priority_selector: directed table, then shuffle rounds.
// Depends on sps_pkg and the block RTL; expectations from an in-bench model or typed rows.
module tb_shuffled_priority_selector;

	localparam int TBL_DEPTH = 32;
	localparam int SEL_DEPTH = 32;
	localparam logic [sps_pkg::REQ_W-1:0] FIRST_UNUSED_REQ = 3'd5;
	localparam logic [sps_pkg::REQ_W-1:0] LAST_UNUSED_REQ  = 3'd7;
	localparam int ROUND_TARGET = 325;
	localparam int DRAIN_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 1100;

	// One row of the directed table; typed rows carry their single expected status
	typedef struct packed {
		logic [sps_pkg::REQ_W-1:0] code;
		logic [sps_pkg::ITEM_W-1:0] id;
		logic [sps_pkg::PICK_W-1:0] pick;
		logic typed;
		sps_pkg::status_code_t sts;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	sps_pkg::request_t request = '0;
	logic result_valid;
	sps_pkg::result_t result;

	// Model state of the block
	logic [sps_pkg::ITEM_W-1:0] tbl_ids [0:TBL_DEPTH-1];
	int tbl_fill = 0;
	int swap_pos = 0;
	bit shuffling = 1'b0;
	logic [sps_pkg::ITEM_W-1:0] sel_ids [0:SEL_DEPTH-1];
	int sel_fill = 0;

	sps_pkg::result_t step_results[$];
	sps_pkg::result_t order_results[$];
	row_t dir_rows[$];
	sps_pkg::result_t exp_r;

	int n_fail = 0;
	int n_items = 0;
	int n_checked = 0;
	int n_emits = 0;
	int longest_emit = 0;
	int n_rounds = 0;
	bit steady = 1'b0;

	shuffled_priority_selector #(
		.TABLE_DEPTH (TBL_DEPTH),
		.SELECT_DEPTH(SEL_DEPTH),
		.ID_WIDTH    (sps_pkg::ITEM_W)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.request     (request),
		.result_valid(result_valid),
		.result      (result)
	);

	// Clock, period 4
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic sps_pkg::result_t mk_result(input sps_pkg::status_code_t sts,
			input logic [sps_pkg::ITEM_W-1:0] id, input logic fnd, input logic lst);
		sps_pkg::result_t r;
		r.status = sts;
		r.out_id = id;
		r.found = fnd;
		r.last = lst;
		return r;
	endfunction

	function automatic sps_pkg::request_t mk_req(input logic [sps_pkg::REQ_W-1:0] code,
			input logic [sps_pkg::ITEM_W-1:0] id, input logic [sps_pkg::PICK_W-1:0] pick);
		sps_pkg::request_t q;
		q.req_type = code;
		q.item_id = id;
		q.random_pick = pick;
		return q;
	endfunction

	function automatic row_t mk_row(input logic [sps_pkg::REQ_W-1:0] code,
			input logic [sps_pkg::ITEM_W-1:0] id, input logic [sps_pkg::PICK_W-1:0] pick,
			input logic typed, input sps_pkg::status_code_t sts);
		row_t w;
		w.code = code;
		w.id = id;
		w.pick = pick;
		w.typed = typed;
		w.sts = sts;
		return w;
	endfunction

	// Ids mostly from a small pool so that table and selection overlap
	function automatic logic [sps_pkg::ITEM_W-1:0] draw_id();
		case ($urandom_range(0, 11))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8001;
			3: return 16'h7FFE;
			4: return 16'hA5A5;
			5: return 16'h5A5A;
			6: return 16'h0F0F;
			7: return 16'h1234;
			default: return 16'($urandom_range(0, 16'hFFFF));
		endcase
	endfunction

	// Idle length after a transfer: mostly none or short, a few long
	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(6, 40);
	endfunction

	// Predict the results of one accepted request and update the model state
	task automatic model_step(input sps_pkg::request_t rq);
		logic [sps_pkg::ITEM_W-1:0] hit_ids[$];
		logic [sps_pkg::ITEM_W-1:0] t;
		bit in_sel;
		step_results.delete();
		case (rq.req_type)
			sps_pkg::REQ_LOAD: begin
				if (shuffling)
					step_results.push_back(mk_result(sps_pkg::STS_BUSY, '0, 1'b0, 1'b1));
				else if (tbl_fill >= TBL_DEPTH)
					step_results.push_back(mk_result(sps_pkg::STS_TABLE_FULL, '0, 1'b0, 1'b1));
				else begin
					tbl_ids[tbl_fill] = rq.item_id;
					tbl_fill++;
					step_results.push_back(mk_result(sps_pkg::STS_OK, '0, 1'b0, 1'b1));
				end
			end
			sps_pkg::REQ_START: begin
				if (shuffling)
					step_results.push_back(mk_result(sps_pkg::STS_BUSY, '0, 1'b0, 1'b1));
				else begin
					if (tbl_fill >= 2) begin
						swap_pos = tbl_fill - 1;
						shuffling = 1'b1;
					end
					step_results.push_back(mk_result(sps_pkg::STS_OK, '0, 1'b0, 1'b1));
				end
			end
			sps_pkg::REQ_SWAP: begin
				if (!shuffling)
					step_results.push_back(mk_result(sps_pkg::STS_NO_SHUFFLE, '0, 1'b0, 1'b1));
				else if (int'(rq.random_pick) > swap_pos)
					step_results.push_back(mk_result(sps_pkg::STS_PICK_RANGE, '0, 1'b0, 1'b1));
				else begin
					t = tbl_ids[rq.random_pick];
					tbl_ids[rq.random_pick] = tbl_ids[swap_pos];
					tbl_ids[swap_pos] = t;
					swap_pos--;
					if (swap_pos == 0)
						shuffling = 1'b0;
					step_results.push_back(mk_result(sps_pkg::STS_OK, '0, 1'b0, 1'b1));
				end
			end
			sps_pkg::REQ_ADD: begin
				if (sel_fill >= SEL_DEPTH)
					step_results.push_back(mk_result(sps_pkg::STS_SEL_FULL, '0, 1'b0, 1'b1));
				else begin
					sel_ids[sel_fill] = rq.item_id;
					sel_fill++;
					step_results.push_back(mk_result(sps_pkg::STS_OK, '0, 1'b0, 1'b1));
				end
			end
			sps_pkg::REQ_EMIT: begin
				if (shuffling)
					step_results.push_back(mk_result(sps_pkg::STS_BUSY, '0, 1'b0, 1'b1));
				else begin
					// walk the table in order, keep each entry found in the selection, up to MAX_RESULTS
					for (int i = 0; i < tbl_fill && hit_ids.size() < sps_pkg::MAX_RESULTS;
							i++) begin
						in_sel = 1'b0;
						for (int j = 0; j < sel_fill; j++)
							if (sel_ids[j] == tbl_ids[i])
								in_sel = 1'b1;
						if (in_sel)
							hit_ids.push_back(tbl_ids[i]);
					end
					sel_fill = 0;
					if (hit_ids.size() == 0)
						step_results.push_back(mk_result(sps_pkg::STS_OK, '0, 1'b0, 1'b1));
					for (int k = 0; k < hit_ids.size(); k++)
						step_results.push_back(mk_result(sps_pkg::STS_OK, hit_ids[k], 1'b1,
							k == hit_ids.size() - 1));
					if (hit_ids.size() > longest_emit)
						longest_emit = hit_ids.size();
					n_emits++;
				end
			end
			default: ;
		endcase
	endtask

	// Drive one request until the block takes it, then record what it should produce
	task automatic send_transfer(input sps_pkg::request_t rq, input logic typed,
			input sps_pkg::status_code_t sts);
		int g;
		start <= 1'b1;
		request <= rq;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		n_items++;
		model_step(rq);
		if (typed)
			order_results.push_back(mk_result(sts, '0, 1'b0, 1'b1));
		else
			foreach (step_results[k])
				order_results.push_back(step_results[k]);
		g = draw_gap();
		if (g > 0) begin
			start <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic issue(input logic [sps_pkg::REQ_W-1:0] code,
			input logic [sps_pkg::ITEM_W-1:0] id, input logic [sps_pkg::PICK_W-1:0] pick);
		send_transfer(mk_req(code, id, pick), 1'b0, sps_pkg::STS_OK);
	endtask

	// Shuffle the table with noise mixed in, fill the selection, then emit
	task automatic shuffle_round(input int kind);
		int r;
		int n;
		steady = ($urandom_range(0, 3) == 0);
		n_rounds++;
		issue(sps_pkg::REQ_START, draw_id(), sps_pkg::PICK_W'($urandom));
		while (shuffling) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				issue(sps_pkg::REQ_SWAP, draw_id(),
					sps_pkg::PICK_W'($urandom_range(0, swap_pos)));
			else if (r < 80 && swap_pos < 31)
				issue(sps_pkg::REQ_SWAP, draw_id(),
					sps_pkg::PICK_W'($urandom_range(swap_pos + 1, 31)));
			else if (r < 88)
				issue(sps_pkg::REQ_ADD, draw_id(), sps_pkg::PICK_W'($urandom));
			else if (r < 92)
				issue(sps_pkg::REQ_LOAD, draw_id(), sps_pkg::PICK_W'($urandom));
			else if (r < 95)
				issue(sps_pkg::REQ_START, draw_id(), sps_pkg::PICK_W'($urandom));
			else if (r < 98)
				issue(sps_pkg::REQ_EMIT, draw_id(), sps_pkg::PICK_W'($urandom));
			else
				issue(sps_pkg::REQ_W'($urandom_range(FIRST_UNUSED_REQ, LAST_UNUSED_REQ)),
					16'($urandom), sps_pkg::PICK_W'($urandom));
		end
		case (kind)
			0: begin
				// select every table id: the emit walks the whole table
				issue(sps_pkg::REQ_EMIT, draw_id(), sps_pkg::PICK_W'($urandom));
				n = tbl_fill;
				for (int i = 0; i < n; i++)
					issue(sps_pkg::REQ_ADD, tbl_ids[i], sps_pkg::PICK_W'($urandom));
				issue(sps_pkg::REQ_ADD, draw_id(), sps_pkg::PICK_W'($urandom));
				issue(sps_pkg::REQ_ADD, draw_id(), sps_pkg::PICK_W'($urandom));
			end
			1: begin
				for (int i = 0; i < SEL_DEPTH + 2; i++)
					issue(sps_pkg::REQ_ADD, draw_id(), sps_pkg::PICK_W'($urandom));
			end
			default: begin
				n = $urandom_range(0, 8);
				for (int i = 0; i < n; i++)
					issue(sps_pkg::REQ_ADD, draw_id(), sps_pkg::PICK_W'($urandom));
			end
		endcase
		issue(sps_pkg::REQ_EMIT, draw_id(), sps_pkg::PICK_W'($urandom));
		steady = 1'b0;
	endtask

	// Result checker; outputs are stable at the falling edge
	always @(negedge clk) begin
		if (arst_n && result_valid) begin
			if (order_results.size() == 0) begin
				if (n_fail < 10)
					$display("ERROR: unexpected result: sts=%0d id=%h found=%b last=%b",
						result.status, result.out_id, result.found, result.last);
				n_fail++;
			end else begin
				exp_r = order_results.pop_front();
				n_checked++;
				if (result.status !== exp_r.status || result.out_id !== exp_r.out_id ||
						result.found !== exp_r.found || result.last !== exp_r.last) begin
					if (n_fail < 10) begin
						$write("ERROR: result %0d exp sts=%0d id=%h found=%b last=%b",
							n_checked, exp_r.status, exp_r.out_id, exp_r.found, exp_r.last);
						$display(", got sts=%0d id=%h found=%b last=%b",
							result.status, result.out_id, result.found, result.last);
					end
					n_fail++;
				end
			end
		end
	end

	// Stimulus
	initial begin
		int drain;
		// directed: empty block, short shuffle, busy and range cases
		dir_rows.push_back(mk_row(sps_pkg::REQ_EMIT,  16'h0000, 5'd0,  1'b1, sps_pkg::STS_OK));
		dir_rows.push_back(mk_row(sps_pkg::REQ_START, 16'h0000, 5'd0,  1'b1, sps_pkg::STS_OK));
		dir_rows.push_back(mk_row(sps_pkg::REQ_SWAP,  16'h0000, 5'd0,  1'b1,
			sps_pkg::STS_NO_SHUFFLE));
		dir_rows.push_back(mk_row(sps_pkg::REQ_LOAD,  16'hFFFF, 5'd0,  1'b1, sps_pkg::STS_OK));
		dir_rows.push_back(mk_row(sps_pkg::REQ_START, 16'h0000, 5'd0,  1'b1, sps_pkg::STS_OK));
		dir_rows.push_back(mk_row(sps_pkg::REQ_SWAP,  16'h0000, 5'd0,  1'b1,
			sps_pkg::STS_NO_SHUFFLE));
		dir_rows.push_back(mk_row(sps_pkg::REQ_LOAD,  16'h0000, 5'd0,  1'b1, sps_pkg::STS_OK));
		dir_rows.push_back(mk_row(sps_pkg::REQ_LOAD,  16'hFFFF, 5'd0,  1'b1, sps_pkg::STS_OK));
		dir_rows.push_back(mk_row(sps_pkg::REQ_LOAD,  16'h1234, 5'd0,  1'b1, sps_pkg::STS_OK));
		dir_rows.push_back(mk_row(sps_pkg::REQ_ADD,   16'hFFFF, 5'd0,  1'b1, sps_pkg::STS_OK));
		dir_rows.push_back(mk_row(sps_pkg::REQ_ADD,   16'h0000, 5'd0,  1'b1, sps_pkg::STS_OK));
		dir_rows.push_back(mk_row(sps_pkg::REQ_EMIT,  16'h0000, 5'd0,  1'b0, sps_pkg::STS_OK));
		dir_rows.push_back(mk_row(sps_pkg::REQ_START, 16'h0000, 5'd0,  1'b1, sps_pkg::STS_OK));
		dir_rows.push_back(mk_row(sps_pkg::REQ_LOAD,  16'h5555, 5'd0,  1'b1, sps_pkg::STS_BUSY));
		dir_rows.push_back(mk_row(sps_pkg::REQ_START, 16'h0000, 5'd0,  1'b1, sps_pkg::STS_BUSY));
		dir_rows.push_back(mk_row(sps_pkg::REQ_EMIT,  16'h0000, 5'd0,  1'b1, sps_pkg::STS_BUSY));
		dir_rows.push_back(mk_row(sps_pkg::REQ_ADD,   16'h1234, 5'd0,  1'b1, sps_pkg::STS_OK));
		dir_rows.push_back(mk_row(sps_pkg::REQ_SWAP,  16'h0000, 5'd31, 1'b1,
			sps_pkg::STS_PICK_RANGE));
		dir_rows.push_back(mk_row(sps_pkg::REQ_SWAP,  16'h0000, 5'd4,  1'b1,
			sps_pkg::STS_PICK_RANGE));
		dir_rows.push_back(mk_row(sps_pkg::REQ_SWAP,  16'h0000, 5'd3,  1'b0, sps_pkg::STS_OK));
		dir_rows.push_back(mk_row(sps_pkg::REQ_SWAP,  16'h0000, 5'd0,  1'b0, sps_pkg::STS_OK));
		dir_rows.push_back(mk_row(sps_pkg::REQ_SWAP,  16'h0000, 5'd1,  1'b0, sps_pkg::STS_OK));
		dir_rows.push_back(mk_row(sps_pkg::REQ_SWAP,  16'h0000, 5'd0,  1'b1,
			sps_pkg::STS_NO_SHUFFLE));
		dir_rows.push_back(mk_row(sps_pkg::REQ_EMIT,  16'h0000, 5'd0,  1'b0, sps_pkg::STS_OK));
		dir_rows.push_back(mk_row(LAST_UNUSED_REQ, 16'hFFFF, 5'd31, 1'b0, sps_pkg::STS_OK));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_transfer(mk_req(dir_rows[i].code, dir_rows[i].id, dir_rows[i].pick),
				dir_rows[i].typed, dir_rows[i].sts);

		// fill the table in steps of 6, 15 and 32 entries, shuffling after each step
		for (int target = 6; target <= TBL_DEPTH;
				target = (target == 6) ? 15 : target + 17) begin
			while (tbl_fill < target) begin
				case ($urandom_range(0, 9))
					0: issue(sps_pkg::REQ_ADD, draw_id(), sps_pkg::PICK_W'($urandom));
					1: issue(sps_pkg::REQ_SWAP, draw_id(), sps_pkg::PICK_W'($urandom));
					2: issue(sps_pkg::REQ_W'($urandom_range(FIRST_UNUSED_REQ, LAST_UNUSED_REQ)),
						16'($urandom), sps_pkg::PICK_W'($urandom));
					default: issue(sps_pkg::REQ_LOAD, draw_id(), sps_pkg::PICK_W'($urandom));
				endcase
			end
			shuffle_round($urandom_range(0, 3));
		end
		// table full
		repeat (3) issue(sps_pkg::REQ_LOAD, draw_id(), sps_pkg::PICK_W'($urandom));

		shuffle_round(0);
		shuffle_round(1);
		while (n_items < ROUND_TARGET)
			shuffle_round($urandom_range(0, 3));

		start <= 1'b0;
		drain = 0;
		while (order_results.size() > 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (order_results.size() > 0) begin
			$display("ERROR: %0d expected results never arrived", order_results.size());
			n_fail += order_results.size();
		end

		$display("Sent %0d transfers over %0d shuffle rounds, checked %0d results.",
			n_items, n_rounds, n_checked);
		$display("%0d emits, longest emit %0d ids, %0d mismatches.",
			n_emits, longest_emit, n_fail);
		if (n_fail == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Watchdog
	initial begin
		#20000000;
		$display("ERROR: timeout, %0d results still expected", order_results.size());
		$display("Verification failed");
		$finish;
	end

endmodule
